// File: rtl/tclut_pkg.sv
package tclut_pkg;

    localparam int NUM_THEMES = 6;
    localparam int NUM_SLOTS  = 10;
    localparam int NUM_INDEX  = 256;

    localparam logic [3:0] NO_SLOT     = 4'(NUM_SLOTS);
    localparam logic [2:0] THEME_DEF   = 3'd0;
    localparam logic [2:0] THEME_LAST  = 3'(NUM_THEMES - 1);
    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    typedef enum logic [1:0] {
        KIND_LOOKUP    = 2'd0,
        KIND_SET       = 2'd1,
        KIND_CLEAR     = 2'd2,
        KIND_CLEAR_ALL = 2'd3
    } t_kind;

    typedef struct packed {
        logic        en;
        t_kind       kind;
        logic [7:0]  index;
        logic [31:0] color;
    } t_ovr_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] color;
    } t_ovr_rsp;

    typedef logic [23:0] t_rgb_rom [NUM_INDEX];

    localparam logic [23:0] EGA_RGB [16] = '{
        24'h000000, 24'h0000aa, 24'h00aa00, 24'h00aaaa,
        24'haa0000, 24'haa00aa, 24'haa5500, 24'haaaaaa,
        24'h555555, 24'h5555ff, 24'h55ff55, 24'h55ffff,
        24'hff5555, 24'hff55ff, 24'hffff55, 24'hffffff
    };

    localparam logic [7:0] CUBE_LEVEL [6] = '{8'h00, 8'h5f, 8'h87, 8'haf, 8'hd7, 8'hff};

    localparam int GRAY_FIRST = 232;
    localparam int GRAY_STEPS = 24;
    localparam int GRAY_BASE  = 8;
    localparam int GRAY_STEP  = 10;

    // slots in order: 15 25 141 143 139 241 246 243 244 245
    localparam logic [23:0] THEME_RGB [NUM_THEMES][NUM_SLOTS] = '{
        '{24'hc0c0c0, 24'h707070, 24'h4040fc, 24'h00007c, 24'h00007c,
          24'h00007c, 24'hc0c0c0, 24'h4040fc, 24'h0004fc, 24'h707070},
        '{24'hdfdfdf, 24'h3a3a3a, 24'h1d1f26, 24'h2b2f3a, 24'h5d8bff,
          24'h2b2f3a, 24'hdfdfdf, 24'h232630, 24'h363d4d, 24'h3a3a3a},
        '{24'hf3e2b2, 24'h4c3a1f, 24'h1f170f, 24'h322313, 24'hbc8a2f,
          24'h322313, 24'hf3e2b2, 24'h281d12, 24'h6e4d1e, 24'h4c3a1f},
        '{24'hd8dde6, 24'h3f4552, 24'h262b33, 24'h343a46, 24'h668ac4,
          24'h343a46, 24'hd8dde6, 24'h2b313b, 24'h3f4f67, 24'h3f4552},
        '{24'hbfd8ff, 24'h1c2a44, 24'h081224, 24'h0d1f3a, 24'h4b90ff,
          24'h0d1f3a, 24'hbfd8ff, 24'h0b1830, 24'h133a74, 24'h1c2a44},
        '{24'hd9e0c8, 24'h364330, 24'h1d271a, 24'h2a3623, 24'h7d9a57,
          24'h2a3623, 24'hd9e0c8, 24'h232e1f, 24'h435a31, 24'h364330}
    };

    function automatic t_rgb_rom build_base();
        t_rgb_rom rom;
        int       n;
        n = 16;
        for (int i = 0; i < 16; i++) begin
            rom[i] = EGA_RGB[i];
        end
        for (int r = 0; r < 6; r++) begin
            for (int g = 0; g < 6; g++) begin
                for (int b = 0; b < 6; b++) begin
                    rom[n] = {CUBE_LEVEL[r], CUBE_LEVEL[g], CUBE_LEVEL[b]};
                    n = n + 1;
                end
            end
        end
        for (int i = 0; i < GRAY_STEPS; i++) begin
            rom[GRAY_FIRST + i] = {3{8'(GRAY_BASE + GRAY_STEP * i)}};
        end
        return rom;
    endfunction

    localparam t_rgb_rom BASE_RGB = build_base();

    function automatic logic [3:0] slot_of(logic [7:0] idx);
        logic [3:0] s;
        case (idx)
            8'd15:   s = 4'd0;
            8'd25:   s = 4'd1;
            8'd141:  s = 4'd2;
            8'd143:  s = 4'd3;
            8'd139:  s = 4'd4;
            8'd241:  s = 4'd5;
            8'd246:  s = 4'd6;
            8'd243:  s = 4'd7;
            8'd244:  s = 4'd8;
            8'd245:  s = 4'd9;
            default: s = NO_SLOT;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/tclut_ovr_store.sv
module tclut_ovr_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tclut_pkg::t_ovr_req i_req,
    output tclut_pkg::t_ovr_rsp o_rsp
);

    logic [31:0] mem [tclut_pkg::NUM_INDEX];
    logic [tclut_pkg::NUM_INDEX-1:0] r_valid;
    logic [tclut_pkg::NUM_INDEX-1:0] n_valid;
    logic        r_hit;
    logic        n_hit;
    logic        r_fwd;
    logic [31:0] r_fwd_color;
    logic [31:0] r_rdata;

    always_comb begin
        n_valid = r_valid;
        n_hit   = r_hit;
        if (i_req.en) begin
            case (i_req.kind)
                tclut_pkg::KIND_LOOKUP: begin
                    n_hit = r_valid[i_req.index];
                end
                tclut_pkg::KIND_SET: begin
                    n_valid[i_req.index] = 1'b1;
                    n_hit = 1'b1;
                end
                tclut_pkg::KIND_CLEAR: begin
                    n_valid[i_req.index] = 1'b0;
                    n_hit = 1'b0;
                end
                tclut_pkg::KIND_CLEAR_ALL: begin
                    n_valid = '0;
                    n_hit = 1'b0;
                end
                default: begin
                    n_hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hit   <= 1'b0;
            r_fwd   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hit   <= n_hit;
            if (i_req.en) begin
                r_fwd <= (i_req.kind == tclut_pkg::KIND_SET);
            end
        end
    end

    // color memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            if (i_req.kind == tclut_pkg::KIND_SET) begin
                mem[i_req.index] <= i_req.color;
            end
            r_rdata     <= mem[i_req.index];
            r_fwd_color <= i_req.color;
        end
    end

    // a set word returns its own color
    assign o_rsp.hit   = r_hit;
    assign o_rsp.color = r_fwd ? r_fwd_color : r_rdata;

endmodule

// File: rtl/tclut_base_color.sv
module tclut_base_color (
    input  logic [7:0]  i_index,
    input  logic [2:0]  i_theme,
    output logic [23:0] o_rgb
);

    logic [3:0] slot;
    logic [2:0] theme_eff;

    assign slot      = tclut_pkg::slot_of(i_index);
    assign theme_eff = (i_theme > tclut_pkg::THEME_LAST) ? tclut_pkg::THEME_DEF : i_theme;

    always_comb begin
        if (slot != tclut_pkg::NO_SLOT) begin
            o_rgb = tclut_pkg::THEME_RGB[theme_eff][slot];
        end else begin
            o_rgb = tclut_pkg::BASE_RGB[i_index];
        end
    end

endmodule

// File: rtl/themed_color_lookup_table_core.sv
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_kind i_index i_*_in
// out       output     o_out_valid / i_out_ready  o_*_out
// cfg       input      i_cfg_we                   i_cfg_wdata (theme)
//
// one word per cycle sustained while the output is not stalled; o_out_valid rises when the word
// moves on: the accepting edge loads the override color read stage, and the output register once it is free
// synchronous active-low reset clears all override valid bits at once, no sweep
// a stalled output holds the read stage, which then stalls the input side
module themed_color_lookup_table_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_index,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_alpha_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out,
    output logic [7:0] o_alpha_out
);

    logic [2:0]  r_theme;
    logic        r_s1_valid;
    logic        n_s1_valid;
    logic [7:0]  r_s1_index;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_rgba;
    logic [31:0] n_out_rgba;
    logic        out_free;
    logic        s1_adv;
    logic        accept;
    logic [23:0] base_rgb;

    tclut_pkg::t_ovr_req ovr_req;
    tclut_pkg::t_ovr_rsp ovr_rsp;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        ovr_req.en    = accept;
        ovr_req.kind  = tclut_pkg::t_kind'(i_kind);
        ovr_req.index = i_index;
        ovr_req.color = {i_red_in, i_green_in, i_blue_in, i_alpha_in};
    end

    tclut_ovr_store u_ovr_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ovr_req),
        .o_rsp   (ovr_rsp)
    );

    tclut_base_color u_base_color (
        .i_index (r_s1_index),
        .i_theme (r_theme),
        .o_rgb   (base_rgb)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_rgba  = r_out_rgba;
        if (s1_adv) begin
            n_out_valid = 1'b1;
            n_out_rgba  = ovr_rsp.hit ? ovr_rsp.color : {base_rgb, tclut_pkg::ALPHA_OPAQUE};
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_theme     <= tclut_pkg::THEME_DEF;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_theme <= i_cfg_wdata;
            end
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_index <= i_index;
        end
        r_out_rgba <= n_out_rgba;
    end

    assign o_out_valid = r_out_valid;
    assign o_red_out   = r_out_rgba[31:24];
    assign o_green_out = r_out_rgba[23:16];
    assign o_blue_out  = r_out_rgba[15:8];
    assign o_alpha_out = r_out_rgba[7:0];

    a_set_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_kind == tclut_pkg::KIND_SET) |=> r_s1_valid && ovr_rsp.hit)
        else $error("set word not seen as override hit");

    a_clear_misses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ((i_kind == tclut_pkg::KIND_CLEAR) || (i_kind == tclut_pkg::KIND_CLEAR_ALL))
        |=> r_s1_valid && !ovr_rsp.hit)
        else $error("cleared index still hits override");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid && $stable(r_s1_index) && $stable(ovr_rsp))
        else $error("read stage lost its word while stalled");

    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid && !r_s1_valid |=> !r_out_valid)
        else $error("output word without a read stage word");

endmodule
